[rtl/core/bsc_pkg.sv]
package bsc_pkg;

  // divider width, one quotient bit per stage
  localparam int DIV_W = 32;

  // queue geometry, shared by the middle and result queues
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam logic [Q_AW:0] Q_FULL = (Q_AW + 1)'(Q_DEPTH);

  // configuration register indexes
  localparam int CFG_IW = 3;
  typedef enum logic [CFG_IW-1:0] {
    CFG_AC1_AC2,
    CFG_AC3_AC4,
    CFG_AC5_AC6,
    CFG_B1_B2,
    CFG_MC_MD,
    CFG_OSS
  } cfg_idx_t;

  // compensation constants
  localparam logic signed [31:0] T_RND   = 32'sd8;
  localparam logic signed [31:0] T_OFS   = 32'sd4000;
  localparam logic [31:0]        X3_OFS  = 32'd32768;
  localparam logic [15:0]        B7_SCL  = 16'd50000;
  localparam logic signed [12:0] P_C1    = 13'sd3038;
  localparam logic signed [13:0] P_C2    = -14'sd7357;
  localparam logic signed [31:0] P_C3    = 32'sd3791;

  // calibration set as seen by the back end
  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic [1:0]         oss;
  } bsc_cal_t;

  // item after the front end: temperature word and shifted pressure
  typedef struct packed {
    logic [15:0] ut;
    logic [23:0] up;
  } bsc_item_t;

  // finished result
  typedef struct packed {
    logic signed [15:0] temp_dc;
    logic signed [31:0] pres_pa;
    logic               div_err;
  } bsc_res_t;

endpackage

[rtl/core/bsc_front.sv]
module bsc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [15:0]                   raw_temp,
  input  logic [23:0]                   raw_pressure,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsc_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [31:0]                   cfg_data,
  output bsc_pkg::bsc_cal_t             cal,
  input  logic                          pop,
  output logic                          empty,
  output bsc_pkg::bsc_item_t            item
);
  import bsc_pkg::*;

  logic [31:0] ac12_r, ac34_r, ac56_r, b12_r, mcmd_r;
  logic [1:0]  oss_r;

  bsc_item_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   cnt_r;
  logic            wr, rd;
  bsc_item_t       wr_item;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac12_r <= '0;
      ac34_r <= '0;
      ac56_r <= '0;
      b12_r  <= '0;
      mcmd_r <= '0;
      oss_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_AC1_AC2: ac12_r <= cfg_data;
        CFG_AC3_AC4: ac34_r <= cfg_data;
        CFG_AC5_AC6: ac56_r <= cfg_data;
        CFG_B1_B2:   b12_r  <= cfg_data;
        CFG_MC_MD:   mcmd_r <= cfg_data;
        CFG_OSS:     oss_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // split the packed calibration words
  always_comb begin
    cal.ac1 = ac12_r[31:16];
    cal.ac2 = ac12_r[15:0];
    cal.ac3 = ac34_r[31:16];
    cal.ac4 = ac34_r[15:0];
    cal.ac5 = ac56_r[31:16];
    cal.ac6 = ac56_r[15:0];
    cal.b1  = b12_r[31:16];
    cal.b2  = b12_r[15:0];
    cal.mc  = mcmd_r[31:16];
    cal.md  = mcmd_r[15:0];
    cal.oss = oss_r;
  end

  // align raw pressure to the oversampling setting
  always_comb begin
    wr_item.ut = raw_temp;
    wr_item.up = raw_pressure >> (4'd8 - 4'(oss_r));
  end

  assign full  = (cnt_r == Q_FULL);
  assign empty = (cnt_r == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign item  = mem_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= rp_r + 1'b1;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/bsc_div.sv]
module bsc_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [bsc_pkg::DIV_W-1:0]  dividend,
  input  logic [bsc_pkg::DIV_W-1:0]  divisor,
  output logic [bsc_pkg::DIV_W-1:0]  quotient
);
  import bsc_pkg::*;

  logic [DIV_W-1:0] rem_r [0:DIV_W];
  logic [DIV_W-1:0] qd_r  [0:DIV_W];
  logic [DIV_W-1:0] dv_r  [0:DIV_W];
  logic [DIV_W-1:0] rem_nxt [1:DIV_W];
  logic [DIV_W-1:0] qd_nxt  [1:DIV_W];
  logic [DIV_W:0]   trial   [1:DIV_W];
  logic             ge      [1:DIV_W];

  // one restoring step per stage, quotient bits shift in behind the dividend
  always_comb begin
    for (int k = 1; k <= DIV_W; k++) begin
      trial[k]   = {rem_r[k-1], qd_r[k-1][DIV_W-1]};
      ge[k]      = trial[k] >= {1'b0, dv_r[k-1]};
      rem_nxt[k] = ge[k] ? DIV_W'(trial[k] - {1'b0, dv_r[k-1]}) : trial[k][DIV_W-1:0];
      qd_nxt[k]  = {qd_r[k-1][DIV_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      qd_r[0]  <= dividend;
      dv_r[0]  <= divisor;
      for (int k = 1; k <= DIV_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        qd_r[k]  <= qd_nxt[k];
        dv_r[k]  <= dv_r[k-1];
      end
    end
  end

  assign quotient = qd_r[DIV_W];

endmodule

[rtl/core/bsc_back.sv]
module bsc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bsc_pkg::bsc_cal_t    cal,
  input  logic                 mid_empty,
  input  bsc_pkg::bsc_item_t   mid_item,
  output logic                 mid_pop,
  input  logic                 oq_full,
  output logic                 oq_push,
  output bsc_pkg::bsc_res_t    oq_data
);
  import bsc_pkg::*;

  logic adv;

  // stage registers
  logic signed [33:0] p1_r;
  logic [23:0]        up1_r, up2_r, up4_r, up5_r, up6_r, up7_r, up8_r, up9_r;
  logic signed [31:0] x1_2_r, den2_r;
  logic signed [31:0] b5_4_r, b6_5_r;
  logic [15:0]        t5_r, t6_r, t7_r, t8_r, t9_r, t10_r, t12_r, t13_r, t14_r;
  logic               e4_r, e5_r, e6_r, e7_r, e8_r, e9_r, e10_r, e12_r, e13_r, e14_r;
  logic signed [31:0] b6sq6_r, x2a6_r, x1b6_r;
  logic signed [31:0] x2a7_r, x1b7_r, x1a7_r, x2b7_r;
  logic signed [31:0] x3_8_r, x3b8_r;
  logic signed [31:0] b3_9_r;
  logic [31:0]        t4_9_r;
  logic [31:0]        b4_10_r, b7_10_r;
  logic signed [31:0] p12_r, p13_r, p14_r;
  logic signed [31:0] x1sq13_r, x2c13_r, x2c14_r, x1c14_r;
  logic               v1_r, v2_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r;
  logic               v12_r, v13_r, v14_r;

  // side data riding along the dividers
  logic signed [31:0] d1_x1_r  [0:DIV_W];
  logic [23:0]        d1_up_r  [0:DIV_W];
  logic               d1_err_r [0:DIV_W];
  logic               d1_neg_r [0:DIV_W];
  logic               d1_v_r   [0:DIV_W];
  logic [15:0]        d2_t_r   [0:DIV_W];
  logic               d2_err_r [0:DIV_W];
  logic               d2_flg_r [0:DIV_W];
  logic               d2_v_r   [0:DIV_W];

  // combinational terms
  logic signed [16:0] d17;
  logic signed [33:0] p1_nxt;
  logic signed [31:0] x1_nxt, den_nxt, num;
  logic [31:0]        dvd1, dvs1, q1, q2, dvd2;
  logic signed [31:0] x2_4, b5p8;
  logic signed [63:0] sq6;
  logic signed [47:0] m_ac2, m_ac3, m_b2, m_b1, sqp, m_c2, m_c1;
  logic signed [31:0] s3b, b3a, b3b, b3s;
  logic [47:0]        m_b4, m_b7;
  logic [31:0]        dd7;
  logic [15:0]        k7;
  logic               flg11;
  logic signed [23:0] p8;
  logic signed [31:0] psum;

  assign adv     = !oq_full;
  assign mid_pop = adv && !mid_empty;

  // temperature front: (ut - ac6) * ac5, then x1 and the divisor
  always_comb begin
    d17     = $signed({1'b0, mid_item.ut}) - $signed({1'b0, cal.ac6});
    p1_nxt  = 34'(d17) * 34'($signed({1'b0, cal.ac5}));
    x1_nxt  = {{13{p1_r[33]}}, p1_r[33:15]};
    den_nxt = x1_nxt + 32'(cal.md);
    num     = {{5{cal.mc[15]}}, cal.mc, 11'b0};
    dvd1    = num[31] ? 32'(-num) : num;
    dvs1    = den2_r[31] ? 32'(-den2_r) : den2_r;
  end

  bsc_div u_div_t (
    .clk      (clk),
    .en       (adv),
    .dividend (dvd1),
    .divisor  (dvs1),
    .quotient (q1)
  );

  // temperature back: b5, b6 and the rounded output
  always_comb begin
    x2_4 = d1_neg_r[DIV_W] ? 32'(-$signed(q1)) : $signed(q1);
    b5p8 = b5_4_r + T_RND;
  end

  // pressure terms: products of b6 and b6 squared, then the sums for b3
  always_comb begin
    sq6   = b6_5_r * b6_5_r;
    m_ac2 = cal.ac2 * b6_5_r;
    m_ac3 = cal.ac3 * b6_5_r;
    m_b2  = cal.b2 * b6sq6_r;
    m_b1  = cal.b1 * b6sq6_r;
    s3b   = x1b7_r + x2b7_r + 32'sd2;
    b3a   = {{14{cal.ac1[15]}}, cal.ac1, 2'b00} + x3_8_r;
    b3b   = b3a <<< cal.oss;
    b3s   = b3b + 32'sd2;
  end

  // b4 and b7, then the divider operands
  always_comb begin
    m_b4  = {32'b0, cal.ac4} * {16'b0, t4_9_r};
    dd7   = {8'b0, up9_r} - b3_9_r;
    k7    = B7_SCL >> cal.oss;
    m_b7  = {16'b0, dd7} * {32'b0, k7};
    flg11 = b7_10_r[31];
    dvd2  = flg11 ? b7_10_r : {b7_10_r[30:0], 1'b0};
  end

  bsc_div u_div_p (
    .clk      (clk),
    .en       (adv),
    .dividend (dvd2),
    .divisor  (b4_10_r),
    .quotient (q2)
  );

  // final pressure correction
  always_comb begin
    p8   = p12_r[31:8];
    sqp  = p8 * p8;
    m_c2 = P_C2 * p12_r;
    m_c1 = x1sq13_r * P_C1;
    psum = x1c14_r + x2c14_r + P_C3;
    oq_data.temp_dc = e14_r ? '0 : t14_r;
    oq_data.pres_pa = e14_r ? '0 : p14_r + {{4{psum[31]}}, psum[31:4]};
    oq_data.div_err = e14_r;
  end

  assign oq_push = adv && v14_r;

  // payload pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r  <= p1_nxt;
      up1_r <= mid_item.up;
      x1_2_r <= x1_nxt;
      den2_r <= den_nxt;
      up2_r  <= up1_r;

      d1_x1_r[0]  <= x1_2_r;
      d1_up_r[0]  <= up2_r;
      d1_err_r[0] <= (den2_r == '0);
      d1_neg_r[0] <= num[31] ^ den2_r[31];
      for (int k = 1; k <= DIV_W; k++) begin
        d1_x1_r[k]  <= d1_x1_r[k-1];
        d1_up_r[k]  <= d1_up_r[k-1];
        d1_err_r[k] <= d1_err_r[k-1];
        d1_neg_r[k] <= d1_neg_r[k-1];
      end

      b5_4_r <= d1_x1_r[DIV_W] + x2_4;
      up4_r  <= d1_up_r[DIV_W];
      e4_r   <= d1_err_r[DIV_W];

      b6_5_r <= b5_4_r - T_OFS;
      t5_r   <= b5p8[19:4];
      up5_r  <= up4_r;
      e5_r   <= e4_r;

      b6sq6_r <= sq6[43:12];
      x2a6_r  <= m_ac2[42:11];
      x1b6_r  <= m_ac3[44:13];
      t6_r    <= t5_r;
      up6_r   <= up5_r;
      e6_r    <= e5_r;

      x1a7_r <= m_b2[42:11];
      x2b7_r <= m_b1[47:16];
      x2a7_r <= x2a6_r;
      x1b7_r <= x1b6_r;
      t7_r   <= t6_r;
      up7_r  <= up6_r;
      e7_r   <= e6_r;

      x3_8_r <= x1a7_r + x2a7_r;
      x3b8_r <= {{2{s3b[31]}}, s3b[31:2]};
      t8_r   <= t7_r;
      up8_r  <= up7_r;
      e8_r   <= e7_r;

      b3_9_r <= {{2{b3s[31]}}, b3s[31:2]};
      t4_9_r <= x3b8_r + X3_OFS;
      t9_r   <= t8_r;
      up9_r  <= up8_r;
      e9_r   <= e8_r;

      b4_10_r <= m_b4[46:15];
      b7_10_r <= m_b7[31:0];
      t10_r   <= t9_r;
      e10_r   <= e9_r;

      d2_t_r[0]   <= t10_r;
      d2_err_r[0] <= e10_r || (b4_10_r == '0);
      d2_flg_r[0] <= flg11;
      for (int k = 1; k <= DIV_W; k++) begin
        d2_t_r[k]   <= d2_t_r[k-1];
        d2_err_r[k] <= d2_err_r[k-1];
        d2_flg_r[k] <= d2_flg_r[k-1];
      end

      p12_r <= d2_flg_r[DIV_W] ? {q2[30:0], 1'b0} : q2;
      t12_r <= d2_t_r[DIV_W];
      e12_r <= d2_err_r[DIV_W];

      x1sq13_r <= sqp[31:0];
      x2c13_r  <= m_c2[47:16];
      p13_r    <= p12_r;
      t13_r    <= t12_r;
      e13_r    <= e12_r;

      x1c14_r <= m_c1[47:16];
      x2c14_r <= x2c13_r;
      p14_r   <= p13_r;
      t14_r   <= t13_r;
      e14_r   <= e13_r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v12_r <= 1'b0;
      v13_r <= 1'b0;
      v14_r <= 1'b0;
      for (int k = 0; k <= DIV_W; k++) begin
        d1_v_r[k] <= 1'b0;
        d2_v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v1_r      <= !mid_empty;
      v2_r      <= v1_r;
      d1_v_r[0] <= v2_r;
      for (int k = 1; k <= DIV_W; k++) begin
        d1_v_r[k] <= d1_v_r[k-1];
        d2_v_r[k] <= d2_v_r[k-1];
      end
      v4_r      <= d1_v_r[DIV_W];
      v5_r      <= v4_r;
      v6_r      <= v5_r;
      v7_r      <= v6_r;
      v8_r      <= v7_r;
      v9_r      <= v8_r;
      v10_r     <= v9_r;
      d2_v_r[0] <= v10_r;
      v12_r     <= d2_v_r[DIV_W];
      v13_r     <= v12_r;
      v14_r     <= v13_r;
    end
  end

endmodule

[rtl/core/bsc_outq.sv]
module bsc_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bsc_pkg::bsc_res_t  wr_data,
  input  logic               pop,
  output logic               empty,
  output logic               full,
  output bsc_pkg::bsc_res_t  rd_data
);
  import bsc_pkg::*;

  bsc_res_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   cnt_r;
  logic            wr, rd;

  assign full    = (cnt_r == Q_FULL);
  assign empty   = (cnt_r == '0);
  assign wr      = push && !full;
  assign rd      = pop && !empty;
  assign rd_data = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= rp_r + 1'b1;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/barometric_sensor_compensation_top.sv]
// channel   direction  handshake            payload
// input     in         push / full          in_raw_temp, in_raw_pressure
// result    out        empty / pop          out_temperature_dc, out_pressure_pa, out_div_error
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item per cycle sustained while the result queue has room;
// the back end holds the two 32-stage pipelined dividers (one quotient bit per stage)
// synchronous active-low reset empties both queues and clears the calibration registers
// a full result queue stalls the whole back pipeline; the middle queue then fills and full rises
// cfg_ready is always high
module barometric_sensor_compensation_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [15:0]                 in_raw_temp,
  input  logic [23:0]                 in_raw_pressure,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [15:0]          out_temperature_dc,
  output logic signed [31:0]          out_pressure_pa,
  output logic                        out_div_error,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bsc_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [31:0]                 cfg_data
);
  import bsc_pkg::*;

  bsc_cal_t  cal;
  bsc_item_t mid_item;
  bsc_res_t  oq_data, res;
  logic      mid_empty, mid_pop, oq_full, oq_push;

  bsc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .raw_temp     (in_raw_temp),
    .raw_pressure (in_raw_pressure),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cal          (cal),
    .pop          (mid_pop),
    .empty        (mid_empty),
    .item         (mid_item)
  );

  bsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cal       (cal),
    .mid_empty (mid_empty),
    .mid_item  (mid_item),
    .mid_pop   (mid_pop),
    .oq_full   (oq_full),
    .oq_push   (oq_push),
    .oq_data   (oq_data)
  );

  bsc_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (oq_push),
    .wr_data (oq_data),
    .pop     (pop),
    .empty   (empty),
    .full    (oq_full),
    .rd_data (res)
  );

  assign out_temperature_dc = res.temp_dc;
  assign out_pressure_pa    = res.pres_pa;
  assign out_div_error      = res.div_err;

endmodule

[rtl/core/bsc_checker.sv]
module bsc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic signed [15:0] out_temperature_dc,
  input logic signed [31:0] out_pressure_pa,
  input logic               out_div_error
);

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // reset leaves room for input
  a_reset_room: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input side full after reset");

  // a flagged result carries zero values
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_div_error) |-> (out_temperature_dc == '0 && out_pressure_pa == '0))
    else $error("division error with nonzero result");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_pressure_pa) && $stable(out_temperature_dc)))
    else $error("waiting result changed");

endmodule

bind barometric_sensor_compensation_top bsc_checker u_bsc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .full               (full),
  .empty              (empty),
  .pop                (pop),
  .out_temperature_dc (out_temperature_dc),
  .out_pressure_pa    (out_pressure_pa),
  .out_div_error      (out_div_error)
);
